// ===== rtl/sts_pkg.sv =====
// shared types, codes and constants of the size string parser
package sts_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int UNIT_WIDTH  = 32;
   localparam int COUNT_WIDTH = 63;

   localparam logic [UNIT_WIDTH-1:0] SECTOR_SIZE_RESET = 32'd512;

   // register index taken from paddr above the byte offset
   localparam logic CSR_SECTOR_SIZE = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   // what the parser hands over when the terminating byte arrives
   typedef struct packed {
      logic       invalid;
      logic [2:0] scale;
      logic       unit_bytes;
   } parse_sum_type;

   // 1024^scale as a left shift
   function automatic logic [5:0] scale_shift(input logic [2:0] scale);
      logic [5:0] result;
      unique case (scale)
         3'd1:    result = 6'd10;
         3'd2:    result = 6'd20;
         3'd3:    result = 6'd30;
         3'd4:    result = 6'd40;
         3'd5:    result = 6'd50;
         3'd6:    result = 6'd60;
         default: result = 6'd0;
      endcase
      return result;
   endfunction

endpackage

// ===== rtl/sts_req_if.sv =====
// input channel: one string byte per transaction
interface sts_req_if;
   import sts_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/sts_rsp_if.sv =====
// result channel: status and sector count per string
interface sts_rsp_if;
   import sts_pkg::*;

   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [COUNT_WIDTH-1:0] sector_count;

   modport source (output valid, output status, output sector_count, input ready);
   modport sink (input valid, input status, input sector_count, output ready);
endinterface

// ===== rtl/sts_scan.sv =====
// byte-wise number and suffix parser
module sts_scan #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [sts_pkg::CHAR_WIDTH-1:0] char_code,
   output sts_pkg::parse_sum_type        summary,
   output logic [VALUE_WIDTH-2:0]        value
);
   import sts_pkg::*;

   localparam int VW1 = VALUE_WIDTH - 1;
   localparam int EW  = VALUE_WIDTH + 3;
   localparam logic [VW1-1:0] VALUE_MAX = {VW1{1'b1}};

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;

   typedef enum logic [2:0] {
      PH_START, PH_SIGNED, PH_ZERO, PH_HEXPFX, PH_NUMBER, PH_SCALED, PH_UNIT
   } phase_type;

   typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX} base_type;

   phase_type      phase_ff, phase_in;
   base_type       base_ff, base_in, acc_base;
   logic           neg_ff, neg_in;
   logic           seen_ff, seen_in;
   logic [VW1-1:0] acc_ff, acc_in, acc_new;
   logic [2:0]     scale_ff, scale_in, char_scale;
   logic           bytes_ff, bytes_in;
   logic           inval_ff, inval_in;

   logic [4:0]     digit;
   logic [4:0]     radix_lim;
   logic [EW-1:0]  acc_ext, acc_prod, acc_sum;
   logic           is_space;
   logic           do_first, do_suffix, do_unit, do_acc;

   always_comb begin
      if (char_code >= CH_0 && char_code <= CH_9) begin
         digit = 5'(char_code - CH_0);
      end else if (char_code >= CH_LA && char_code <= CH_LF) begin
         digit = 5'(char_code - CH_LA) + 5'd10;
      end else if (char_code >= CH_UA && char_code <= CH_UF) begin
         digit = 5'(char_code - CH_UA) + 5'd10;
      end else begin
         digit = 5'd16;
      end
   end

   always_comb begin
      unique case (char_code)
         8'h6B, 8'h4B: char_scale = 3'd1;
         8'h6D, 8'h4D: char_scale = 3'd2;
         8'h67, 8'h47: char_scale = 3'd3;
         8'h74, 8'h54: char_scale = 3'd4;
         8'h70, 8'h50: char_scale = 3'd5;
         8'h65, 8'h45: char_scale = 3'd6;
         default:      char_scale = 3'd0;
      endcase
   end

   assign is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);

   always_comb begin
      unique case (base_ff)
         BASE_OCT: radix_lim = 5'd8;
         BASE_HEX: radix_lim = 5'd16;
         default:  radix_lim = 5'd10;
      endcase
   end

   // the base a digit taken now is weighed in
   always_comb begin
      unique case (phase_ff)
         PH_START, PH_SIGNED: acc_base = BASE_DEC;
         PH_HEXPFX:           acc_base = BASE_HEX;
         default:             acc_base = base_ff;
      endcase
   end

   // saturating multiply-accumulate: acc * radix + digit, clamped at max
   always_comb begin
      acc_ext = EW'(acc_ff);
      unique case (acc_base)
         BASE_OCT: acc_prod = acc_ext << 3;
         BASE_HEX: acc_prod = acc_ext << 4;
         default:  acc_prod = (acc_ext << 3) + (acc_ext << 1);
      endcase
      acc_sum = acc_prod + EW'(digit[3:0]);
      acc_new = (acc_sum > EW'(VALUE_MAX)) ? VALUE_MAX : acc_sum[VW1-1:0];
   end

   always_comb begin
      phase_in  = phase_ff;
      base_in   = base_ff;
      neg_in    = neg_ff;
      seen_in   = seen_ff;
      acc_in    = acc_ff;
      scale_in  = scale_ff;
      bytes_in  = bytes_ff;
      inval_in  = inval_ff;
      do_first  = 1'b0;
      do_suffix = 1'b0;
      do_unit   = 1'b0;
      do_acc    = 1'b0;
      if (take && char_code == CH_NUL) begin
         phase_in = PH_START;
         base_in  = BASE_DEC;
         neg_in   = 1'b0;
         seen_in  = 1'b0;
         acc_in   = '0;
         scale_in = 3'd0;
         bytes_in = 1'b0;
         inval_in = 1'b0;
      end else if (take && !inval_ff) begin
         unique case (phase_ff)
            PH_START: begin
               if (is_space) begin
                  phase_in = PH_START;
               end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
                  neg_in   = (char_code == CH_MINUS);
                  phase_in = PH_SIGNED;
               end else begin
                  do_first = 1'b1;
               end
            end
            PH_SIGNED: do_first = 1'b1;
            PH_ZERO: begin
               if (char_code == 8'h78 || char_code == 8'h58) begin
                  phase_in = PH_HEXPFX;
               end else if (digit < 5'd8) begin
                  phase_in = PH_NUMBER;
                  do_acc   = 1'b1;
               end else begin
                  phase_in  = PH_NUMBER;
                  do_suffix = 1'b1;
               end
            end
            PH_HEXPFX: begin
               if (digit < 5'd16) begin
                  base_in  = BASE_HEX;
                  phase_in = PH_NUMBER;
                  do_acc   = 1'b1;
               end else begin
                  inval_in = 1'b1;
               end
            end
            PH_NUMBER: begin
               if (digit < radix_lim) begin
                  do_acc = 1'b1;
               end else begin
                  do_suffix = 1'b1;
               end
            end
            PH_SCALED: do_unit = 1'b1;
            default:   inval_in = 1'b1;
         endcase

         // first digit after optional sign; a lone zero switches to octal
         if (do_first) begin
            if (char_code == CH_0) begin
               seen_in  = 1'b1;
               base_in  = BASE_OCT;
               phase_in = PH_ZERO;
            end else if (char_code >= CH_1 && char_code <= CH_9) begin
               base_in  = BASE_DEC;
               phase_in = PH_NUMBER;
               do_acc   = 1'b1;
            end else begin
               inval_in = 1'b1;
            end
         end

         if (do_suffix) begin
            if (char_scale != 3'd0) begin
               scale_in = char_scale;
               bytes_in = 1'b1;
               phase_in = PH_SCALED;
            end else begin
               do_unit = 1'b1;
            end
         end

         if (do_unit) begin
            if (char_code == 8'h73 || char_code == 8'h53) begin
               bytes_in = 1'b0;
               phase_in = PH_UNIT;
            end else if (char_code == 8'h62 || char_code == 8'h42) begin
               bytes_in = 1'b1;
               phase_in = PH_UNIT;
            end else begin
               inval_in = 1'b1;
            end
         end

         if (do_acc) begin
            acc_in  = acc_new;
            seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         base_ff  <= BASE_DEC;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         acc_ff   <= '0;
         scale_ff <= 3'd0;
         bytes_ff <= 1'b0;
         inval_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         neg_ff   <= neg_in;
         seen_ff  <= seen_in;
         acc_ff   <= acc_in;
         scale_ff <= scale_in;
         bytes_ff <= bytes_in;
         inval_ff <= inval_in;
      end
   end

   assign summary.invalid = inval_ff || !seen_ff || phase_ff == PH_START ||
                            phase_ff == PH_SIGNED || phase_ff == PH_HEXPFX ||
                            (neg_ff && acc_ff != '0);
   assign summary.scale      = scale_ff;
   assign summary.unit_bytes = bytes_ff;
   assign value              = acc_ff;

endmodule

// ===== rtl/sts_calc.sv =====
// sequencer around one shared adder: shift-add multiply, range check, restoring divide
module sts_calc #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  sts_pkg::parse_sum_type         summary,
   input  logic [VALUE_WIDTH-2:0]         value,
   input  logic [sts_pkg::UNIT_WIDTH-1:0] sector_size,
   output logic                           busy,
   sts_rsp_if.source                      rsp
);
   import sts_pkg::*;

   localparam int VW1       = VALUE_WIDTH - 1;
   localparam int PW        = VW1 + UNIT_WIDTH;
   localparam int MUL_STEPS = UNIT_WIDTH;
   localparam int DIV_STEPS = VW1;
   localparam int CW        = $clog2(DIV_STEPS > MUL_STEPS ? DIV_STEPS : MUL_STEPS);
   localparam logic [CW-1:0] MUL_LAST = CW'(MUL_STEPS - 1);
   localparam logic [CW-1:0] DIV_LAST = CW'(DIV_STEPS - 1);
   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {VW1{1'b1}}};

   typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CHECK, ST_DIV, ST_FINISH} state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [VW1-1:0]         num_ff, num_in;
   logic [UNIT_WIDTH-1:0]  unit_ff, unit_in;
   logic [UNIT_WIDTH-1:0]  mplr_ff, mplr_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [VW1-1:0]         quo_ff, quo_in;
   logic [UNIT_WIDTH-1:0]  rem_ff, rem_in;
   logic [2:0]             scale_ff, scale_in;
   status_type             stat_ff, stat_in;
   logic                   out_valid_ff, out_valid_in;
   status_type             out_status_ff, out_status_in;
   logic [COUNT_WIDTH-1:0] out_count_ff, out_count_in;

   logic                   alu_sub;
   logic [PW-1:0]          alu_a, alu_b;
   logic [PW:0]            alu_sum;
   logic                   alu_carry;
   logic [UNIT_WIDTH:0]    rem_shift;
   logic [5:0]             shift;
   logic [VALUE_WIDTH-1:0] lim;
   logic [PW-1:0]          scaled;
   logic                   range_err;

   assign rem_shift = {rem_ff, quo_ff[VW1-1]};

   // shared adder: add for the multiply, subtract for the divide
   always_comb begin
      if (state_ff == ST_MUL) begin
         alu_sub = 1'b0;
         alu_a   = prod_ff << 1;
         alu_b   = mplr_ff[UNIT_WIDTH-1] ? PW'(num_ff) : '0;
      end else begin
         alu_sub = 1'b1;
         alu_a   = PW'(rem_shift);
         alu_b   = PW'(sector_size);
      end
      alu_sum   = {1'b0, alu_a} + {1'b0, alu_b ^ {PW{alu_sub}}} + (PW + 1)'(alu_sub);
      alu_carry = alu_sum[PW];
   end

   // total = value * unit * 2^shift; in range when unit and product both fit max >> shift
   assign shift     = scale_shift(scale_ff);
   assign lim       = VALUE_MAX >> shift;
   assign range_err = (PW'(unit_ff) > PW'(lim)) || (prod_ff > PW'(lim));
   assign scaled    = prod_ff << shift;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      num_in        = num_ff;
      unit_in       = unit_ff;
      mplr_in       = mplr_ff;
      prod_in       = prod_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      scale_in      = scale_ff;
      stat_in       = stat_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = value;
               scale_in = summary.scale;
               unit_in  = summary.unit_bytes ? UNIT_WIDTH'(1) : sector_size;
               mplr_in  = summary.unit_bytes ? UNIT_WIDTH'(1) : sector_size;
               prod_in  = '0;
               cnt_in   = '0;
               if (summary.invalid || sector_size == '0) begin
                  stat_in  = STATUS_INVALID;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in = alu_sum[PW-1:0];
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (range_err) begin
               stat_in  = STATUS_RANGE;
               state_in = ST_FINISH;
            end else begin
               quo_in   = scaled[VW1-1:0];
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = alu_carry ? alu_sum[UNIT_WIDTH-1:0] : rem_shift[UNIT_WIDTH-1:0];
            quo_in = {quo_ff[VW1-2:0], alu_carry};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               stat_in  = (rem_in != '0) ? STATUS_INVALID : STATUS_OK;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = stat_ff;
               out_count_in  = (stat_ff == STATUS_OK) ? COUNT_WIDTH'(quo_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      num_ff        <= num_in;
      unit_ff       <= unit_in;
      mplr_ff       <= mplr_in;
      prod_ff       <= prod_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      scale_ff      <= scale_in;
      stat_ff       <= stat_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.sector_count = out_count_ff;

endmodule

// ===== rtl/size_string_to_sectors_core.sv =====
// Size string to sector count. Bytes of the string are taken one per cycle
// while sts_calc is not busy; every nonzero byte is parsed in the cycle it
// is accepted. The terminating zero byte starts the final computation in
// the shared adder of sts_calc: a shift-add multiply by the unit, a range
// check, a restoring divide by sector_size and a load of the result
// register. req.ready stays low through all of these steps, and longer while
// the previous result still sits untaken in the output register. Strings
// found invalid, and a zero sector_size, go straight to the result load;
// out of range strings skip the divide. A finished result waits in the
// output register while the next string is already being accepted.
// sector_size sits at byte address 0 of the APB-style port and resets to 512.
module size_string_to_sectors_core #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   sts_req_if.sink                        req,
   sts_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [sts_pkg::UNIT_WIDTH-1:0] pwdata,
   output logic [sts_pkg::UNIT_WIDTH-1:0] prdata,
   output logic                           pready
);
   import sts_pkg::*;

   logic [UNIT_WIDTH-1:0] sector_size_ff;
   logic                  busy;
   logic                  take;
   logic                  start;
   parse_sum_type         summary;
   logic [VALUE_WIDTH-2:0] value;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_SECTOR_SIZE) ? sector_size_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_size_ff <= SECTOR_SIZE_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_SECTOR_SIZE) begin
         sector_size_ff <= pwdata;
      end
   end

   assign req.ready = !busy;
   assign take      = req.valid && req.ready;
   assign start     = take && (req.char_code == '0);

   sts_scan #(.VALUE_WIDTH(VALUE_WIDTH)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req.char_code),
      .summary   (summary),
      .value     (value)
   );

   sts_calc #(.VALUE_WIDTH(VALUE_WIDTH)) u_calc (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .summary     (summary),
      .value       (value),
      .sector_size (sector_size_ff),
      .busy        (busy),
      .rsp         (rsp)
   );

endmodule

// ===== rtl/sts_check.sv =====
// port-level checks of the size string parser and their bind
module sts_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [sts_pkg::CHAR_WIDTH-1:0]  req_char_code,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_status,
   input logic [sts_pkg::COUNT_WIDTH-1:0] rsp_sector_count
);
   import sts_pkg::*;

   // a failed string never reports a count
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_sector_count == '0)
      else $error("nonzero sector count with error status");

   // the terminating byte always starts a computation that drops req.ready
   a_end_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_char_code == '0 |=> !req_ready)
      else $error("input still ready after terminating byte");

   // a new result only comes out of the busy sequencer
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a computation");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_sector_count))
      else $error("stalled result changed");

endmodule

bind size_string_to_sectors_core sts_check u_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_char_code    (req.char_code),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_sector_count (rsp.sector_count)
);

// ===== bench/tb_top.sv =====
// testbench of the size string parser: directed strings, random strings, sector size sweep
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sts_pkg::*;

   localparam int VALUE_WIDTH = 64;
   localparam logic [63:0] VALUE_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam logic [2:0] SECTOR_SIZE_ADDR = {CSR_SECTOR_SIZE, 2'b00};
   localparam int SETTLE_CYCLES = 110;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int MAX_REPORTS = 40;
   localparam int ROW_COUNT = 25;

   typedef enum logic [2:0] {
      AT_START, AFTER_SIGN, AFTER_ZERO, AFTER_HEX_PREFIX, IN_NUMBER, AFTER_SCALE, AFTER_UNIT
   } parse_phase_type;

   typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_type;

   typedef struct packed {
      status_type             status;
      logic [COUNT_WIDTH-1:0] count;
   } sector_result_type;

   typedef struct {
      string                  text;
      bit                     has_known;
      status_type             status;
      logic [COUNT_WIDTH-1:0] count;
   } string_case_type;

   typedef logic [7:0] text_type[$];

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [UNIT_WIDTH-1:0] pwdata, prdata;

   sts_req_if req_if ();
   sts_rsp_if rsp_if ();

   size_string_to_sectors_core #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // parser copy kept in step with accepted bytes
   parse_phase_type phase;
   radix_type radix;
   bit negative, seen_digit, bytes_unit, bad_string;
   logic [63:0] accum;
   logic [2:0] scale;
   logic [UNIT_WIDTH-1:0] sector_size_q;

   sector_result_type expected_results[$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_count = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   string_case_type directed_rows [ROW_COUNT] = '{
      '{"", 1'b1, STATUS_INVALID, 63'd0},
      '{" \011\012\013\014\015", 1'b1, STATUS_INVALID, 63'd0},
      '{"+", 1'b1, STATUS_INVALID, 63'd0},
      '{"-0", 1'b1, STATUS_OK, 63'd0},
      '{"-5", 1'b1, STATUS_INVALID, 63'd0},
      '{"0", 1'b1, STATUS_OK, 63'd0},
      '{"1", 1'b1, STATUS_OK, 63'd1},
      '{" \011\012\013\014\015+42", 1'b0, STATUS_OK, 63'd0},
      '{"0x", 1'b1, STATUS_INVALID, 63'd0},
      '{"0xg", 1'b1, STATUS_INVALID, 63'd0},
      '{"0X1bE", 1'b0, STATUS_OK, 63'd0},
      '{"017", 1'b0, STATUS_OK, 63'd0},
      '{"09", 1'b1, STATUS_INVALID, 63'd0},
      '{"1k", 1'b1, STATUS_OK, 63'd2},
      '{"3Mb", 1'b0, STATUS_OK, 63'd0},
      '{"2gS", 1'b0, STATUS_OK, 63'd0},
      '{"5pB", 1'b0, STATUS_OK, 63'd0},
      '{"1e", 1'b0, STATUS_OK, 63'd0},
      '{"8E", 1'b1, STATUS_RANGE, 63'd0},
      '{"1024B", 1'b0, STATUS_OK, 63'd0},
      '{"100b", 1'b1, STATUS_INVALID, 63'd0},
      '{"99999999999999999999", 1'b1, STATUS_RANGE, 63'd0},
      '{"0xFFFFFFFFFFFFFFFFFs", 1'b0, STATUS_OK, 63'd0},
      '{"1kbx", 1'b1, STATUS_INVALID, 63'd0},
      '{"12 \377\200", 1'b1, STATUS_INVALID, 63'd0}
   };

   function automatic void clear_parse();
      phase = AT_START;
      radix = RADIX_DEC;
      negative = 1'b0;
      seen_digit = 1'b0;
      accum = '0;
      scale = '0;
      bytes_unit = 1'b0;
      bad_string = 1'b0;
   endfunction

   function automatic logic [63:0] digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 16;
   endfunction

   function automatic logic [63:0] radix_value();
      case (radix)
         RADIX_OCT: return 8;
         RADIX_HEX: return 16;
         default:   return 10;
      endcase
   endfunction

   function automatic void add_digit(input logic [63:0] d);
      logic [63:0] r;
      r = radix_value();
      if (accum > (VALUE_MAX - d) / r) accum = VALUE_MAX;
      else accum = accum * r + d;
      seen_digit = 1'b1;
   endfunction

   function automatic void take_unit(input logic [7:0] c);
      case (c)
         "s", "S": begin
            bytes_unit = 1'b0;
            phase = AFTER_UNIT;
         end
         "b", "B": begin
            bytes_unit = 1'b1;
            phase = AFTER_UNIT;
         end
         default: bad_string = 1'b1;
      endcase
   endfunction

   function automatic void take_suffix(input logic [7:0] c);
      logic [2:0] power;
      case (c)
         "k", "K": power = 3'd1;
         "m", "M": power = 3'd2;
         "g", "G": power = 3'd3;
         "t", "T": power = 3'd4;
         "p", "P": power = 3'd5;
         "e", "E": power = 3'd6;
         default:  power = 3'd0;
      endcase
      if (power != 0) begin
         scale = power;
         bytes_unit = 1'b1;
         phase = AFTER_SCALE;
      end else begin
         take_unit(c);
      end
   endfunction

   function automatic void first_digit(input logic [7:0] c);
      if (c == "0") begin
         seen_digit = 1'b1;
         radix = RADIX_OCT;
         phase = AFTER_ZERO;
      end else if (c >= "1" && c <= "9") begin
         radix = RADIX_DEC;
         phase = IN_NUMBER;
         add_digit(digit_of(c));
      end else begin
         bad_string = 1'b1;
      end
   endfunction

   function automatic sector_result_type close_string();
      sector_result_type res;
      logic [63:0] mult, unit, total;
      res.status = STATUS_OK;
      res.count = '0;
      if (bad_string || !seen_digit || phase == AFTER_HEX_PREFIX || phase == AT_START ||
          phase == AFTER_SIGN || (negative && accum != 0) || sector_size_q == 0) begin
         res.status = STATUS_INVALID;
      end else begin
         mult = 64'd1 << (10 * scale);
         unit = bytes_unit ? 64'd1 : {32'd0, sector_size_q};
         if (VALUE_MAX / unit < mult || VALUE_MAX / mult / unit < accum) begin
            res.status = STATUS_RANGE;
         end else begin
            total = accum * mult * unit;
            if (total % sector_size_q != 0) res.status = STATUS_INVALID;
            else res.count = COUNT_WIDTH'(total / sector_size_q);
         end
      end
      return res;
   endfunction

   // returns 1 when the byte ends a string and res holds its outcome
   function automatic bit parse_byte(input logic [7:0] c, output sector_result_type res);
      logic [63:0] d;
      res = '0;
      if (c == 0) begin
         res = close_string();
         clear_parse();
         return 1'b1;
      end
      if (bad_string) return 1'b0;
      d = digit_of(c);
      case (phase)
         AT_START: begin
            if (c == " " || (c >= "\011" && c <= "\015")) begin
               // leading white space is skipped
            end else if (c == "+" || c == "-") begin
               negative = (c == "-");
               phase = AFTER_SIGN;
            end else begin
               first_digit(c);
            end
         end
         AFTER_SIGN: first_digit(c);
         AFTER_ZERO: begin
            if (c == "x" || c == "X") begin
               phase = AFTER_HEX_PREFIX;
            end else if (d < 8) begin
               phase = IN_NUMBER;
               add_digit(d);
            end else begin
               phase = IN_NUMBER;
               take_suffix(c);
            end
         end
         AFTER_HEX_PREFIX: begin
            if (d < 16) begin
               radix = RADIX_HEX;
               phase = IN_NUMBER;
               add_digit(d);
            end else begin
               bad_string = 1'b1;
            end
         end
         IN_NUMBER: begin
            if (d < radix_value()) add_digit(d);
            else take_suffix(c);
         end
         AFTER_SCALE: take_unit(c);
         default: bad_string = 1'b1;
      endcase
      return 1'b0;
   endfunction

   function automatic logic [7:0] pick(input string chars);
      return chars[$urandom_range(chars.len() - 1)];
   endfunction

   function automatic text_type random_text();
      text_type q;
      int n, r;
      logic [7:0] b;
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
         q.push_back(pick(" \011\012\013\014\015"));
      r = $urandom_range(99);
      if (r < 12) q.push_back("+");
      else if (r < 22) q.push_back("-");
      n = ($urandom_range(19) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
      r = $urandom_range(9);
      if (r < 6) begin
         q.push_back(pick("123456789"));
         repeat (n - 1) q.push_back(pick("0123456789"));
      end else if (r < 8) begin
         q.push_back("0");
         q.push_back(pick("xX"));
         repeat (n) q.push_back(pick("0123456789abcdefABCDEF"));
      end else begin
         q.push_back("0");
         repeat (n - 1) q.push_back(pick("01234567"));
      end
      r = $urandom_range(99);
      if (r >= 35 && r < 75) begin
         q.push_back(pick("kmgtpeKMGTPE"));
         if ($urandom_range(1)) q.push_back(pick("bBsS"));
      end else if (r >= 75) begin
         q.push_back(pick("bBsS"));
      end
      // one string in five is damaged or pure noise
      if ($urandom_range(4) == 0) begin
         case ($urandom_range(2))
            0: begin
               b = 8'($urandom_range(1, 255));
               q[$urandom_range(q.size() - 1)] = b;
            end
            1: repeat ($urandom_range(1, 3)) begin
               b = 8'($urandom_range(1, 255));
               q.push_back(b);
            end
            default: begin
               q.delete();
               repeat ($urandom_range(6)) begin
                  b = 8'($urandom_range(1, 255));
                  q.push_back(b);
               end
            end
         endcase
      end
      return q;
   endfunction

   task automatic send_byte(input logic [7:0] c, input bit has_known,
                            input sector_result_type known);
      sector_result_type res;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_code <= c;
      do @(posedge clock); while (!req_if.ready);
      if (parse_byte(c, res)) expected_results.push_back(has_known ? known : res);
   endtask

   task automatic send_text(input text_type q, input bit has_known,
                            input sector_result_type known);
      foreach (q[i]) send_byte(q[i], 1'b0, '0);
      send_byte(8'd0, has_known, known);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write sector_size, then read it back
   task automatic set_sector_size(input logic [UNIT_WIDTH-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SECTOR_SIZE_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sector_size_q = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         if (mismatch_count < MAX_REPORTS)
            $display("%0t: sector_size read back expected %0d actual %0d", $time, value, prdata);
         mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [UNIT_WIDTH-1:0] size, input int send_pct,
                            input int stall_pct, input int budget, input bit hold);
      text_type q;
      int sent;
      wait_idle();
      set_sector_size(size);
      send_idle_pct = send_pct;
      recv_stall_pct <= stall_pct;
      if (hold) hold_count <= hold_count + 1;
      sent = 0;
      while (sent < budget) begin
         q = random_text();
         send_text(q, 1'b0, '0);
         sent += q.size() + 1;
      end
   endtask

   // result receiver with random stalls and an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_count != hold_seen) begin
         hold_seen <= hold_count;
         hold_left <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      sector_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: result with none expected: status %0d count %0d",
                        $time, rsp_if.status, rsp_if.sector_count);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.status !== want.status) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_if.status);
               mismatch_count++;
            end
            if (rsp_if.sector_count !== want.count) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: sector_count expected %0d actual %0d",
                           $time, want.count, rsp_if.sector_count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      text_type q;
      sector_result_type known;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.char_code <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      sector_size_q = SECTOR_SIZE_RESET;
      clear_parse();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed strings at the reset sector size
      foreach (directed_rows[r]) begin
         q.delete();
         for (int i = 0; i < directed_rows[r].text.len(); i++)
            q.push_back(directed_rows[r].text[i]);
         known.status = directed_rows[r].status;
         known.count = directed_rows[r].count;
         send_text(q, directed_rows[r].has_known, known);
      end

      run_phase(32'd1, 0, 0, 290, 1'b0);
      run_phase(32'd4096, 45, 0, 280, 1'b0);
      run_phase(32'hFFFF_FFFF, 0, 45, 280, 1'b0);
      run_phase(32'd512, 22, 22, 280, 1'b1);
      run_phase($urandom_range(1, 15) << $urandom_range(0, 16), 22, 22, 280, 1'b0);
      run_phase(32'd0, 0, 0, 60, 1'b0);
      run_phase(32'd3, 22, 22, 220, 1'b0);
      wait_idle();

      if (mismatch_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sts_pkg.sv
rtl/sts_req_if.sv
rtl/sts_rsp_if.sv
rtl/sts_scan.sv
rtl/sts_calc.sv
rtl/size_string_to_sectors_core.sv
rtl/sts_check.sv
bench/tb_top.sv
